/* sv/tnpm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tnpm_pkg;

  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned SQ_W      = 64;
  localparam int unsigned SUM_W     = 65;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QPOS   = 2'd2,
    ACT_QTIME  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] arc_s;
    logic signed [31:0] time_value;
  } in_t;

  typedef struct packed {
    status_e                status;
    logic [OUT_IDX_W-1:0]   out_index;
    logic signed [31:0]     match_s;
    logic signed [31:0]     match_x;
    logic signed [31:0]     match_y;
    logic signed [31:0]     match_time;
  } out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] s;
    logic signed [31:0] t;
  } point_t;

endpackage

`default_nettype wire

/* sv/tnpm_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module tnpm_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [ADDR_W-1:0]   wr_addr_i,
  input  wire tnpm_pkg::point_t    wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [ADDR_W-1:0]   rd_addr_i,
  output tnpm_pkg::point_t         rd_data_o
);

  tnpm_pkg::point_t mem_q [DEPTH];
  tnpm_pkg::point_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* sv/tnpm_dist.sv */
`timescale 1ns / 1ps
`default_nettype none

module tnpm_dist #(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire logic [IDX_W-1:0]              idx_i,
  input  wire logic signed [31:0]            px_i,
  input  wire logic signed [31:0]            py_i,
  input  wire logic signed [31:0]            qx_i,
  input  wire logic signed [31:0]            qy_i,
  output logic                               valid_o,
  output logic [IDX_W-1:0]                   idx_o,
  output logic [tnpm_pkg::SUM_W-1:0]         sum_o
);

  logic signed [32:0]             dx;
  logic signed [32:0]             dy;
  logic [31:0]                    ax_d;
  logic [31:0]                    ay_d;
  logic [31:0]                    ax_q;
  logic [31:0]                    ay_q;
  logic [tnpm_pkg::SQ_W-1:0]      sx_q;
  logic [tnpm_pkg::SQ_W-1:0]      sy_q;
  logic [tnpm_pkg::SUM_W-1:0]     sum_q;
  logic [2:0]                     v_q;
  logic [IDX_W-1:0]               idx_a_q;
  logic [IDX_W-1:0]               idx_m_q;
  logic [IDX_W-1:0]               idx_s_q;

  // absolute coordinate differences
  always_comb begin
    dx   = {px_i[31], px_i} - {qx_i[31], qx_i};
    dy   = {py_i[31], py_i} - {qy_i[31], qy_i};
    ax_d = dx[32] ? 32'(-dx) : dx[31:0];
    ay_d = dy[32] ? 32'(-dy) : dy[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    idx_a_q <= idx_i;
    sx_q    <= ax_q * ax_q;
    sy_q    <= ay_q * ay_q;
    idx_m_q <= idx_a_q;
    sum_q   <= {1'b0, sx_q} + {1'b0, sy_q};
    idx_s_q <= idx_m_q;
  end

  assign valid_o = v_q[2];
  assign idx_o   = idx_s_q;
  assign sum_o   = sum_q;

endmodule

`default_nettype wire

/* sv/trajectory_nearest_point_matcher.sv */
// latency: clear and append results can transfer 2 cycles after the input transfer
// position query: n + 8 cycles, n stored points, one memory read per cycle
// time query: up to n + 6 cycles, scan stops at the first point at or after the query time
// throughput: one item at a time; a finished result can wait in a skid register
// reset (async, active low) empties the table and zeroes the time offset; no memory clearing pass
`timescale 1ns / 1ps
`default_nettype none

module trajectory_nearest_point_matcher #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire tnpm_pkg::in_t      in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output tnpm_pkg::out_t          out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [31:0]        cfg_wdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PSCAN,
    S_TSCAN,
    S_TPICK,
    S_FETCH,
    S_EMIT
  } state_e;

  state_e                        state_q, state_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic signed [31:0]            hdr_q, hdr_d;
  logic [CNT_W-1:0]              scan_q, scan_d;
  logic                          rv_q, rv_d;
  logic [IDX_W-1:0]              ridx_q, ridx_d;
  logic [IDX_W-1:0]              last_q, last_d;
  logic signed [31:0]            qx_q, qx_d;
  logic signed [31:0]            qy_q, qy_d;
  logic signed [32:0]            rel_q, rel_d;
  logic [tnpm_pkg::SUM_W-1:0]    best_sum_q, best_sum_d;
  logic [IDX_W-1:0]              best_idx_q, best_idx_d;
  logic signed [32:0]            prev_q, prev_d;
  logic signed [33:0]            after_q, after_d;
  logic signed [33:0]            before_q, before_d;
  logic [IDX_W-1:0]              sel_q, sel_d;
  tnpm_pkg::out_t                res_q, res_d;
  logic                          pend_q, pend_d;
  tnpm_pkg::out_t                out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic                          in_acc;
  logic                          mem_we;
  tnpm_pkg::point_t              mem_wdata;
  logic                          mem_re;
  logic [IDX_W-1:0]              mem_raddr;
  tnpm_pkg::point_t              mem_rdata;
  logic                          issue;
  logic                          dv;
  logic [IDX_W-1:0]              didx;
  logic [tnpm_pkg::SUM_W-1:0]    dsum;
  logic                          take;
  logic signed [32:0]            t_ext;
  logic                          t_ge;

  assign in_ready_o  = (state_q == S_IDLE) && !pend_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign issue = ((state_q == S_PSCAN) || (state_q == S_TSCAN)) && (scan_q < cnt_q);

  always_comb begin
    mem_we    = in_acc && (in_data_i.action == tnpm_pkg::ACT_APPEND)
                && (cnt_q != CNT_W'(MAX_POINTS));
    mem_wdata = '{x: in_data_i.pos_x, y: in_data_i.pos_y,
                  s: in_data_i.arc_s, t: in_data_i.time_value};
    mem_re    = issue || (state_q == S_FETCH);
    mem_raddr = (state_q == S_FETCH) ? sel_q : scan_q[IDX_W-1:0];
  end

  tnpm_mem #(
    .DEPTH  (MAX_POINTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (cnt_q[IDX_W-1:0]),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_raddr),
    .rd_data_o (mem_rdata)
  );

  tnpm_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rv_q && (state_q == S_PSCAN)),
    .idx_i   (ridx_q),
    .px_i    (mem_rdata.x),
    .py_i    (mem_rdata.y),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .valid_o (dv),
    .idx_o   (didx),
    .sum_o   (dsum)
  );

  assign take  = (didx == '0) || (dsum < best_sum_q);
  assign t_ext = {mem_rdata.t[31], mem_rdata.t};
  assign t_ge  = t_ext >= rel_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hdr_d       = cfg_we_i ? cfg_wdata_i : hdr_q;
    scan_d      = issue ? scan_q + CNT_W'(1) : scan_q;
    rv_d        = issue;
    ridx_d      = scan_q[IDX_W-1:0];
    last_d      = last_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    rel_d       = rel_q;
    best_sum_d  = best_sum_q;
    best_idx_d  = best_idx_q;
    prev_d      = prev_q;
    after_d     = after_q;
    before_d    = before_q;
    sel_d       = sel_q;
    res_d       = res_q;
    pend_d      = pend_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    // skid register to output register
    if (pend_q && (!out_valid_q || out_ready_i)) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
      pend_d      = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d  = '0;
          scan_d = '0;
          last_d = IDX_W'(cnt_q - CNT_W'(1));
          qx_d   = in_data_i.pos_x;
          qy_d   = in_data_i.pos_y;
          rel_d  = {in_data_i.time_value[31], in_data_i.time_value} - {hdr_q[31], hdr_q};
          case (in_data_i.action)
            tnpm_pkg::ACT_CLEAR: begin
              cnt_d        = '0;
              res_d.status = tnpm_pkg::ST_OK;
              pend_d       = 1'b1;
            end
            tnpm_pkg::ACT_APPEND: begin
              pend_d = 1'b1;
              if (cnt_q == CNT_W'(MAX_POINTS)) begin
                res_d.status = tnpm_pkg::ST_FULL;
              end else begin
                cnt_d      = cnt_q + CNT_W'(1);
                res_d      = '{status: tnpm_pkg::ST_OK,
                               out_index: tnpm_pkg::OUT_IDX_W'(cnt_q),
                               match_s: in_data_i.arc_s,
                               match_x: in_data_i.pos_x,
                               match_y: in_data_i.pos_y,
                               match_time: in_data_i.time_value};
              end
            end
            default: begin
              if (cnt_q == '0) begin
                res_d.status = tnpm_pkg::ST_EMPTY;
                pend_d       = 1'b1;
              end else if (in_data_i.action == tnpm_pkg::ACT_QPOS) begin
                state_d = S_PSCAN;
              end else begin
                state_d = S_TSCAN;
              end
            end
          endcase
        end
      end
      S_PSCAN: begin
        if (dv) begin
          if (take) begin
            best_sum_d = dsum;
            best_idx_d = didx;
          end
          if (didx == last_q) begin
            sel_d   = take ? didx : best_idx_q;
            state_d = S_FETCH;
          end
        end
      end
      S_TSCAN: begin
        if (rv_q) begin
          if (t_ge) begin
            after_d  = {t_ext[32], t_ext} - {rel_q[32], rel_q};
            before_d = {rel_q[32], rel_q} - {prev_q[32], prev_q};
            sel_d    = ridx_q;
            state_d  = (ridx_q == '0) ? S_FETCH : S_TPICK;
          end else begin
            prev_d = t_ext;
            if (ridx_q == last_q) begin
              sel_d   = ridx_q;
              state_d = S_FETCH;
            end
          end
        end
      end
      S_TPICK: begin
        // ties go to the earlier point
        if (!(after_q < before_q)) begin
          sel_d = sel_q - IDX_W'(1);
        end
        state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        res_d   = '{status: tnpm_pkg::ST_OK,
                    out_index: tnpm_pkg::OUT_IDX_W'(sel_q),
                    match_s: mem_rdata.s,
                    match_x: mem_rdata.x,
                    match_y: mem_rdata.y,
                    match_time: mem_rdata.t};
        pend_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      hdr_q       <= '0;
      scan_q      <= '0;
      rv_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hdr_q       <= hdr_d;
      scan_q      <= scan_d;
      rv_q        <= rv_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= ridx_d;
    last_q     <= last_d;
    qx_q       <= qx_d;
    qy_q       <= qy_d;
    rel_q      <= rel_d;
    best_sum_q <= best_sum_d;
    best_idx_q <= best_idx_d;
    prev_q     <= prev_d;
    after_q    <= after_d;
    before_q   <= before_d;
    sel_q      <= sel_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POINTS))
    else $error("point count above table depth");

  a_dist_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv |-> state_q == S_PSCAN)
    else $error("distance result outside position scan");

  a_tscan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TSCAN) && rv_q |-> ridx_q <= last_q)
    else $error("time scan read beyond last point");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.action == tnpm_pkg::ACT_QPOS
               || in_data_i.action == tnpm_pkg::ACT_QTIME) && (cnt_q != '0)
    |=> !pend_q && !in_ready_o)
    else $error("query on filled table did not start a scan");

endmodule

`default_nettype wire
